>>> hw/rtl/pewt_pkg.sv
package pewt_pkg;

    localparam int CHANNELS = 4;
    localparam int TASKS    = 64;

    // Fixed field widths
    localparam int CH_W     = 2;
    localparam int PRIO_W   = 6;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int MASK_W   = 64;
    localparam int FIRED_W  = 4;

    // Register file
    localparam int NUM_REGS = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef logic [CH_W-1:0]     t_chan;
    typedef logic [PRIO_W-1:0]   t_prio;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [MASK_W-1:0]   t_mask;
    typedef logic [FIRED_W-1:0]  t_fired;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [DATA_W-1:0]   t_data;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_WAIT = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode opcode;
        t_chan   channel;
        t_prio   task_prio;
        t_time   now_ms;
    } t_item;

    typedef struct packed {
        t_mask  woken_mask;
        t_fired fired_channels;
        logic   need_switch;
    } t_result;

    // Only the low TASKS priorities exist
    localparam t_mask TASK_MASK = (TASKS >= MASK_W) ? {MASK_W{1'b1}}
                                                    : ((t_mask'(1) << TASKS) - t_mask'(1));

    localparam t_period PERIOD_RST [4] = '{t_period'(100), t_period'(200),
                                           t_period'(500), t_period'(50)};

    // Reset period; channels beyond the fourth repeat the pattern
    function automatic t_period period_reset(input int unsigned idx);
        return PERIOD_RST[2'(idx)];
    endfunction

endpackage

>>> hw/rtl/pewt_ifs.sv
interface pewt_item_if;
    logic              valid;
    logic              ready;
    pewt_pkg::t_opcode opcode;
    pewt_pkg::t_chan   channel;
    pewt_pkg::t_prio   task_prio;
    pewt_pkg::t_time   now_ms;

    modport source (output valid, opcode, channel, task_prio, now_ms, input ready);
    modport sink   (input valid, opcode, channel, task_prio, now_ms, output ready);
endinterface

interface pewt_result_if;
    logic             valid;
    logic             ready;
    pewt_pkg::t_mask  woken_mask;
    pewt_pkg::t_fired fired_channels;
    logic             need_switch;

    modport source (output valid, woken_mask, fired_channels, need_switch, input ready);
    modport sink   (input valid, woken_mask, fired_channels, need_switch, output ready);
endinterface

>>> hw/rtl/pewt_cfg_regs.sv
module pewt_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  pewt_pkg::t_addr       paddr,
    input  pewt_pkg::t_data       pwdata,
    output pewt_pkg::t_data       prdata,
    output logic                  pready,
    output pewt_pkg::t_period     o_period [pewt_pkg::CHANNELS]
);

    pewt_pkg::t_period r_period [pewt_pkg::CHANNELS];
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
                r_period[c] <= pewt_pkg::period_reset(c);
            end
        end else if (wr_en) begin
            for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
                // channels without a register keep their reset period
                if (c < pewt_pkg::NUM_REGS && int'(reg_idx) == c) begin
                    r_period[c] <= pwdata[pewt_pkg::PERIOD_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
            if (c < pewt_pkg::NUM_REGS && int'(reg_idx) == c) begin
                prdata = pewt_pkg::DATA_W'(r_period[c]);
            end
        end
    end

    assign o_period = r_period;

endmodule

>>> hw/rtl/pewt_core.sv
module pewt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  pewt_pkg::t_item     i_item,
    input  pewt_pkg::t_period   i_period [pewt_pkg::CHANNELS],
    output pewt_pkg::t_result   o_result
);

    pewt_pkg::t_time r_next [pewt_pkg::CHANNELS];
    pewt_pkg::t_mask r_wait [pewt_pkg::CHANNELS];
    pewt_pkg::t_time n_next [pewt_pkg::CHANNELS];
    pewt_pkg::t_mask n_wait [pewt_pkg::CHANNELS];

    pewt_pkg::t_mask               woken;
    logic [pewt_pkg::CHANNELS-1:0] fired;

    always_comb begin
        woken  = '0;
        fired  = '0;
        n_next = r_next;
        n_wait = r_wait;
        if (i_item.opcode == pewt_pkg::OP_WAIT) begin
            for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
                if (int'(i_item.channel) == c && int'(i_item.task_prio) < pewt_pkg::TASKS) begin
                    n_wait[c][i_item.task_prio] = 1'b1;
                end
            end
        end else begin
            // all channels compare against now in parallel
            for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
                if (r_next[c] <= i_item.now_ms) begin
                    woken     = woken | r_wait[c];
                    n_wait[c] = '0;
                    n_next[c] = r_next[c] + pewt_pkg::TIME_W'(i_period[c]);
                    fired[c]  = 1'b1;
                end
            end
            woken = woken & pewt_pkg::TASK_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < pewt_pkg::CHANNELS; c++) begin
                r_next[c] <= pewt_pkg::TIME_W'(pewt_pkg::period_reset(c));
                r_wait[c] <= '0;
            end
        end else if (i_go) begin
            r_next <= n_next;
            r_wait <= n_wait;
        end
    end

    assign o_result.woken_mask     = woken;
    assign o_result.fired_channels = pewt_pkg::FIRED_W'(fired);
    assign o_result.need_switch    = |woken;

endmodule

>>> hw/rtl/periodic_event_wakeup_timer.sv
// Channel  | Dir | Handshake            | Payload
// i_item   | in  | valid/ready          | opcode, channel, task_prio, now_ms
// o_res    | out | valid/ready          | woken_mask, fired_channels, need_switch
// APB cfg  | in  | psel/penable/pready  | period_ch0..3 at byte 0x0/0x4/0x8/0xC
//
// One item per cycle sustained while the receiver takes every result; each item passes the
// input register, then the channel compare/add/clear logic into the result register, from
// which its result leaves once the receiver is ready.
// Synchronous active-low reset clears waiter sets and loads next-match with each reset period.
// A stalled result holds in the output register; the input register keeps accepting
// as long as the output register frees up in the same cycle.
module periodic_event_wakeup_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pewt_item_if.sink           i_item,
    pewt_result_if.source       o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  pewt_pkg::t_addr     paddr,
    input  pewt_pkg::t_data     pwdata,
    output pewt_pkg::t_data     prdata,
    output logic                pready
);

    pewt_pkg::t_period period [pewt_pkg::CHANNELS];

    // input stage
    logic              r_in_valid;
    pewt_pkg::t_item   r_in;
    // result stage
    logic              r_out_valid;
    pewt_pkg::t_result r_out;

    pewt_pkg::t_result core_res;
    logic              out_free;
    logic              advance;
    logic              in_take;

    // result slot free when empty or draining this cycle
    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || advance;

    pewt_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_period (period)
    );

    // state commits only when the item moves into the result register
    pewt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (advance),
        .i_item   (r_in),
        .i_period (period),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode    <= i_item.opcode;
            r_in.channel   <= i_item.channel;
            r_in.task_prio <= i_item.task_prio;
            r_in.now_ms    <= i_item.now_ms;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.woken_mask     = r_out.woken_mask;
    assign o_res.fired_channels = r_out.fired_channels;
    assign o_res.need_switch    = r_out.need_switch;

endmodule

>>> sim/pewt_check_pkg.sv
package pewt_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import pewt_pkg::*;

    // Shadow copy of the timer: periods, next-match times and waiter sets.
    // Every accepted item queues the result the block owes for it.
    class wakeup_shadow;
        t_period     span_ms [CHANNELS];
        t_time       due_ms  [CHANNELS];
        t_mask       sleepers[CHANNELS];
        t_result     owed_results[$];
        int unsigned errors;
        int unsigned results_checked;
        int unsigned ticks;
        int unsigned waits;
        int unsigned firings;
        int unsigned switches;

        function new();
            for (int c = 0; c < CHANNELS; c++) begin
                span_ms[c]  = PERIOD_RST[c];
                due_ms[c]   = t_time'(PERIOD_RST[c]);
                sleepers[c] = '0;
            end
        endfunction

        // Period writes leave the next-match time where it is
        function void set_span(input int idx, input t_period value);
            span_ms[idx] = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void take_item(input t_opcode op, input t_chan ch, input t_prio prio,
                                input t_time now_ms);
            t_result r;
            r = '0;
            if (op == OP_WAIT) begin
                waits++;
                // waits on a missing channel or priority are dropped
                if (int'(ch) < CHANNELS && int'(prio) < TASKS)
                    sleepers[ch] |= t_mask'(1) << prio;
            end else begin
                ticks++;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (due_ms[c] <= now_ms) begin
                        r.woken_mask        |= sleepers[c];
                        sleepers[c]          = '0;
                        due_ms[c]            = due_ms[c] + t_time'(span_ms[c]);
                        r.fired_channels[c]  = 1'b1;
                        firings++;
                    end
                end
                r.woken_mask  &= TASK_MASK;
                r.need_switch  = |r.woken_mask;
                if (r.need_switch)
                    switches++;
            end
            owed_results.push_back(r);
        endfunction

        function void match_result(input t_mask woken, input t_fired fired, input logic need_sw);
            t_result want;
            results_checked++;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result with none owed, expected nothing, actual %h/%h/%b",
                         $time, woken, fired, need_sw);
                return;
            end
            want = owed_results.pop_front();
            if (want.woken_mask !== woken) begin
                errors++;
                $display("%0t: woken_mask expected %h actual %h", $time, want.woken_mask, woken);
            end
            if (want.fired_channels !== fired) begin
                errors++;
                $display("%0t: fired_channels expected %h actual %h",
                         $time, want.fired_channels, fired);
            end
            if (want.need_switch !== need_sw) begin
                errors++;
                $display("%0t: need_switch expected %b actual %b",
                         $time, want.need_switch, need_sw);
            end
        endfunction
    endclass

endpackage

>>> sim/periodic_event_wakeup_timer_test.sv
module periodic_event_wakeup_timer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pewt_pkg::*;
    import pewt_check_pkg::*;

    // Receiver hold-off: starts once this many results were checked, lasts this long
    localparam int HOLD_AT     = 1000;
    localparam int HOLD_CYCLES = 300;
    // Max-period items at the top of time
    localparam int TOP_ITEMS   = 100;

    logic    i_clk;
    logic    i_rst_n;
    logic    psel;
    logic    penable;
    logic    pwrite;
    t_addr   paddr;
    t_data   pwdata;
    t_data   prdata;
    logic    pready;

    pewt_item_if   item_bus ();
    pewt_result_if res_bus ();

    wakeup_shadow board = new();

    // Running millisecond clock for well-formed tick streams
    t_time       cur_ms;
    // No idling on either side while set
    bit          steady;
    int unsigned period_writes;

    periodic_event_wakeup_timer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #(1ms);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off counted here
    // so the block backs up and stalls its input while items keep coming.
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        res_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && board.results_checked >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= steady || ($urandom_range(99) >= 32);
            end
        end
    end

    // Results are compared at the edge where they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            board.match_result(res_bus.woken_mask, res_bus.fired_channels, res_bus.need_switch);
    end

    // Offers one item, with random idle cycles ahead of it, and returns at the
    // falling edge after it was taken. valid stays up for a back-to-back item.
    task automatic send_item(input t_opcode op, input t_chan ch, input t_prio prio,
                             input t_time now_ms);
        while (!steady && $urandom_range(99) < 32) begin
            item_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.opcode    <= op;
        item_bus.channel   <= ch;
        item_bus.task_prio <= prio;
        item_bus.now_ms    <= now_ms;
        do @(posedge i_clk); while (!item_bus.ready);
        board.take_item(op, ch, prio, now_ms);
        @(negedge i_clk);
    endtask

    // Drop valid and let every owed result come back; the block is idle after
    task automatic drain();
        item_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // APB write (setup, access), then read the register back
    task automatic write_period(input int idx, input t_period value);
        t_data got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'(4 * idx);
        // upper bits are don't-care for a 16-bit period
        pwdata  <= {t_period'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_span(idx, value);
        period_writes++;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== t_data'(board.span_ms[idx])) begin
            board.errors++;
            $display("%0t: period %0d readback expected %h actual %h",
                     $time, idx, t_data'(board.span_ms[idx]), got);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Restart the running clock just below the earliest next-match time,
    // so the following ticks walk through real firings.
    task automatic realign_clock();
        t_time low;
        low = board.due_ms[0];
        for (int c = 1; c < CHANNELS; c++) begin
            if (board.due_ms[c] < low)
                low = board.due_ms[c];
        end
        cur_ms = (low > 150) ? low - 150 : '0;
    endtask

    // Mostly waits and forward-moving ticks; some late jumps, extremes and
    // fully random times as noise. Unused fields always carry random values.
    task automatic send_random(input int count);
        int    pick;
        t_time stamp;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_item(OP_WAIT, t_chan'($urandom_range(3)), t_prio'($urandom_range(63)),
                          t_time'($urandom));
            end else begin
                if (pick < 45) begin
                    stamp = t_time'($urandom);
                end else if (pick < 48) begin
                    stamp = ($urandom_range(1) == 1) ? {TIME_W{1'b1}} : t_time'(0);
                end else begin
                    // forward tick: sometimes a late jump of up to 3000 ms, else a small step of up to 40 ms
                    if (pick < 54)
                        cur_ms += t_time'($urandom_range(3000));
                    else
                        cur_ms += t_time'($urandom_range(40));
                    stamp = cur_ms;
                end
                send_item(OP_TICK, t_chan'($urandom_range(3)), t_prio'($urandom_range(63)),
                          stamp);
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.opcode    <= OP_TICK;
        item_bus.channel   <= '0;
        item_bus.task_prio <= '0;
        item_bus.now_ms    <= '0;
        steady             = 1'b0;
        cur_ms             = '0;
        period_writes      = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: default periods 100/200/500/50 ---
        // lowest and highest priority, a repeated wait, alternating bit patterns
        send_item(OP_WAIT, 2'd0, 6'd0,  t_time'($urandom));
        send_item(OP_WAIT, 2'd0, 6'd63, t_time'($urandom));
        send_item(OP_WAIT, 2'd0, 6'd63, t_time'($urandom));
        send_item(OP_WAIT, 2'd3, 6'd42, t_time'($urandom));
        send_item(OP_WAIT, 2'd1, 6'd21, t_time'($urandom));
        send_item(OP_WAIT, 2'd2, 6'd1,  t_time'($urandom));
        // time zero and just short of a match fire nothing
        send_item(OP_TICK, 2'd0, 6'd0, t_time'(0));
        send_item(OP_TICK, 2'd1, 6'd5, t_time'(49));
        // exact match on channel 3
        send_item(OP_TICK, 2'd2, 6'd9, t_time'(50));
        send_item(OP_TICK, 2'd3, 6'd7, t_time'(99));
        // two channels match at once
        send_item(OP_TICK, 2'd0, 6'd3, t_time'(100));
        // very late tick: everything fires, but advances one period only
        send_item(OP_TICK, 2'd1, 6'd0, {TIME_W{1'b1}});
        // fires again with empty waiter sets, so no switch
        send_item(OP_TICK, 2'd2, 6'd0, {TIME_W{1'b1}});
        send_item(OP_WAIT, 2'd1, 6'd63, t_time'($urandom));
        send_item(OP_WAIT, 2'd2, 6'd0,  t_time'($urandom));
        send_item(OP_TICK, 2'd3, 6'd63, t_time'(0));
        send_item(OP_TICK, 2'd0, 6'd21, 32'h5555_5555);
        send_item(OP_TICK, 2'd3, 6'd42, 32'hAAAA_AAAA);

        // --- random with reset periods ---
        realign_clock();
        send_random(600);
        drain();

        // --- extremes: period one, full range, zero (fires every due tick) ---
        write_period(0, t_period'(1));
        write_period(1, {PERIOD_W{1'b1}});
        write_period(2, t_period'(0));
        write_period(3, t_period'($urandom_range(1, 65535)));
        // the long receiver hold-off falls in this phase
        realign_clock();
        send_random(600);
        drain();

        // --- mid-range periods, first part with no idling at all ---
        for (int c = 0; c < CHANNELS; c++)
            write_period(c, t_period'($urandom_range(20, 300)));
        realign_clock();
        steady = 1'b1;
        send_random(300);
        steady = 1'b0;
        send_random(300);
        drain();

        // --- max periods, every tick at the top of time ---
        for (int c = 0; c < CHANNELS; c++)
            write_period(c, {PERIOD_W{1'b1}});
        for (int n = 0; n < TOP_ITEMS; n++) begin
            if ($urandom_range(63) == 0)
                send_item(OP_WAIT, t_chan'($urandom_range(3)), t_prio'($urandom_range(63)),
                          t_time'($urandom));
            else
                send_item(OP_TICK, t_chan'($urandom_range(3)), t_prio'($urandom_range(63)),
                          {TIME_W{1'b1}});
        end
        drain();

        // --- short periods to finish ---
        for (int c = 0; c < CHANNELS; c++)
            write_period(c, t_period'($urandom_range(1, 100)));
        realign_clock();
        send_random(200);
        drain();

        // give stray results time to show
        repeat (20) @(posedge i_clk);

        $display("Covered %0d ticks and %0d waits, %0d channel firings, %0d wakeups with switch.",
                 board.ticks, board.waits, board.firings, board.switches);
        $display("Periods programmed %0d times incl. zero, one and max; late ticks included.",
                 period_writes);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pewt_pkg.sv
hw/rtl/pewt_ifs.sv
hw/rtl/pewt_cfg_regs.sv
hw/rtl/pewt_core.sv
hw/rtl/periodic_event_wakeup_timer.sv
sim/pewt_check_pkg.sv
sim/periodic_event_wakeup_timer_test.sv
